FILE: rtl/mse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, sizes and helpers of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

   localparam int MAX_ITEMS  = 32;
   localparam int DATA_WIDTH = 32;

   // buffer index, element count (holds MAX_ITEMS itself) and headroom for sums
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int EXT_W = CNT_W + 2;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_out;
      logic                         overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREP,
      ST_READ,
      ST_MERGE,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic sort_init;
      logic merge;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic sort_needed;
      logic merge_done;
      logic emit_final;
   } status_type;

   // smaller of a widened position and the element count
   function automatic logic [CNT_W-1:0] clip_to_count(input logic [EXT_W-1:0] x,
                                                      input logic [CNT_W-1:0] n);
      logic [EXT_W-1:0] n_ext;
      n_ext = {{(EXT_W-CNT_W){1'b0}}, n};
      return (x > n_ext) ? n : x[CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/mse_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

FILE: rtl/mse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: load, merge passes (read then merge per element), emission.
// ----------------------------------------------------------------------------
module mse_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               last_in,
   input  wire mse_pkg::status_type status,
   output logic                    busy,
   output mse_pkg::cmd_type        cmd
);

   mse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mse_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         mse_pkg::ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (last_in) begin
                  state_in = mse_pkg::ST_PREP;
               end
            end
         end
         mse_pkg::ST_PREP: begin
            cmd.sort_init = 1'b1;
            state_in = status.sort_needed ? mse_pkg::ST_READ : mse_pkg::ST_EMIT;
         end
         mse_pkg::ST_READ: begin
            state_in = mse_pkg::ST_MERGE;
         end
         mse_pkg::ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in = status.merge_done ? mse_pkg::ST_EMIT : mse_pkg::ST_READ;
         end
         mse_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_final) begin
               state_in = mse_pkg::ST_FLUSH;
            end
         end
         mse_pkg::ST_FLUSH: begin
            // final item leaves this cycle
            cmd.clear = 1'b1;
            state_in  = mse_pkg::ST_LOAD;
         end
         default: begin
            state_in = mse_pkg::ST_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/mse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_datapath
// Ping-pong buffers, run pointers and the compare-and-select merge step.
// ----------------------------------------------------------------------------
module mse_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mse_pkg::cmd_type   cmd,
   input  wire mse_pkg::req_type   req_data,
   output mse_pkg::status_type     status,
   output logic                    rsp_valid,
   output mse_pkg::rsp_type        rsp_data
);

   localparam int IDX_W = mse_pkg::IDX_W;
   localparam int CNT_W = mse_pkg::CNT_W;
   localparam int EXT_W = mse_pkg::EXT_W;
   localparam int DW    = mse_pkg::DATA_WIDTH;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] w_ff, w_in;
   logic [CNT_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic             src_ff, src_in;
   logic             ovf_ff, ovf_in;
   logic             emit_v_ff, emit_v_in;
   logic             emit_last_ff, emit_last_in;

   logic             wr0_en, wr1_en;
   logic [IDX_W-1:0] wr0_addr;
   logic [DW-1:0]    wr0_data;
   logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
   logic [DW-1:0]    rd0_a, rd0_b, rd1_a, rd1_b;

   logic signed [DW-1:0] head_a, head_b, merge_data;
   logic                 take_a;
   logic [CNT_W-1:0]     k_next;
   logic [EXT_W-1:0]     w2, w4, seg_mid, seg_hi, n_ext;
   logic                 pass_end;
   logic                 buf_full;

   always_comb begin
      n_ext     = {{(EXT_W-CNT_W){1'b0}}, count_ff};
      head_a    = src_ff ? rd1_a : rd0_a;
      head_b    = src_ff ? rd1_b : rd0_b;
      // equal heads: right run goes first
      take_a    = (a_ff < mid_ff) && ((b_ff >= hi_ff) || (head_a < head_b));
      merge_data = take_a ? head_a : head_b;
      k_next    = k_ff + 1'b1;
      w2        = {{(EXT_W-CNT_W){1'b0}}, w_ff} << 1;
      w4        = w2 << 1;
      seg_mid   = {{(EXT_W-CNT_W){1'b0}}, hi_ff} + {{(EXT_W-CNT_W){1'b0}}, w_ff};
      seg_hi    = {{(EXT_W-CNT_W){1'b0}}, hi_ff} + w2;
      pass_end  = (k_next == hi_ff) && (hi_ff == count_ff);
      buf_full  = (count_ff == CNT_W'(mse_pkg::MAX_ITEMS));

      status.sort_needed = (count_ff > CNT_W'(1));
      status.merge_done  = pass_end && (w2 >= n_ext);
      status.emit_final  = (k_next == count_ff);
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      src_in       = src_ff;
      emit_v_in    = 1'b0;
      emit_last_in = emit_last_ff;

      if (cmd.load) begin
         if (buf_full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.sort_init) begin
         w_in   = CNT_W'(1);
         src_in = 1'b0;
         a_in   = '0;
         k_in   = '0;
         mid_in = mse_pkg::clip_to_count(EXT_W'(1), count_ff);
         b_in   = mse_pkg::clip_to_count(EXT_W'(1), count_ff);
         hi_in  = mse_pkg::clip_to_count(EXT_W'(2), count_ff);
      end

      if (cmd.merge) begin
         a_in = take_a ? a_ff + 1'b1 : a_ff;
         b_in = take_a ? b_ff : b_ff + 1'b1;
         k_in = k_next;
         if (pass_end) begin
            // next pass reads what this one wrote
            w_in   = w2[CNT_W-1:0];
            src_in = ~src_ff;
            a_in   = '0;
            k_in   = '0;
            mid_in = mse_pkg::clip_to_count(w2, count_ff);
            b_in   = mse_pkg::clip_to_count(w2, count_ff);
            hi_in  = mse_pkg::clip_to_count(w4, count_ff);
         end else if (k_next == hi_ff) begin
            a_in   = hi_ff;
            mid_in = mse_pkg::clip_to_count(seg_mid, count_ff);
            b_in   = mse_pkg::clip_to_count(seg_mid, count_ff);
            hi_in  = mse_pkg::clip_to_count(seg_hi, count_ff);
         end
      end

      if (cmd.emit) begin
         k_in         = k_next;
         emit_v_in    = 1'b1;
         emit_last_in = status.emit_final;
      end

      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         emit_v_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         emit_v_ff <= emit_v_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      src_ff       <= src_in;
      emit_last_ff <= emit_last_in;
   end

   always_comb begin
      rd_addr_a = cmd.emit ? k_ff[IDX_W-1:0] : a_ff[IDX_W-1:0];
      rd_addr_b = b_ff[IDX_W-1:0];
      wr0_en    = (cmd.load && !buf_full) || (cmd.merge && src_ff);
      wr0_addr  = cmd.load ? count_ff[IDX_W-1:0] : k_ff[IDX_W-1:0];
      wr0_data  = cmd.load ? req_data.value : merge_data;
      wr1_en    = cmd.merge && !src_ff;
   end

   mse_ram #(
      .WIDTH (DW),
      .DEPTH (mse_pkg::MAX_ITEMS)
   ) u_ram_data (
      .clock     (clock),
      .wr_en     (wr0_en),
      .wr_addr   (wr0_addr),
      .wr_data   (wr0_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd0_a),
      .rd_data_b (rd0_b)
   );

   mse_ram #(
      .WIDTH (DW),
      .DEPTH (mse_pkg::MAX_ITEMS)
   ) u_ram_scratch (
      .clock     (clock),
      .wr_en     (wr1_en),
      .wr_addr   (k_ff[IDX_W-1:0]),
      .wr_data   (merge_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd1_a),
      .rd_data_b (rd1_b)
   );

   always_comb begin
      rsp_valid             = emit_v_ff;
      rsp_data.sorted_value = head_a;
      rsp_data.last_out     = emit_last_ff;
      rsp_data.overflowed   = ovf_ff;
   end

endmodule
`default_nettype wire

FILE: rtl/merge_sort_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sort_engine_unit
// Block sorter: collects signed elements, merge sorts them, emits ascending.
// ----------------------------------------------------------------------------
// usage:
//  - an item (req_data) is taken on a clock edge with start high and busy low;
//    last_in closes the block. up to MAX_ITEMS elements are kept, later ones
//    are dropped and every result of that block shows overflowed
//  - a non-final item is taken and busy stays low
//  - after the final item busy rises: a set-up state, then bottom-up merge
//    passes, ceil(log2 n) of them; for each element a pass does a registered
//    read of both run heads from the buffer ram, then a compare and write
//  - results follow, one per cycle on rsp_valid/rsp_data, last_out on the
//    final one; busy falls after the final result
//  - results cannot be held off: each is shown for exactly one cycle
//  - synchronous reset empties the block and returns to loading; buffer
//    contents are not cleared and need not be
// ----------------------------------------------------------------------------
module merge_sort_engine_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mse_pkg::req_type req_data,
   output logic                  rsp_valid,
   output mse_pkg::rsp_type      rsp_data
);

   mse_pkg::cmd_type    cmd;
   mse_pkg::status_type status;

   mse_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .last_in (req_data.last_in),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   mse_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: rtl/mse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the merge sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module mse_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire mse_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire mse_pkg::rsp_type rsp_data
);

   // results only come out while a block is being worked on
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result shown while idle");

   // a non-final item does not start the sort
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.last_in) |=> !busy)
      else $error("busy after non-final item");

   // the final item starts the sort
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last_in) |=> busy)
      else $error("not busy after final item");

   // nothing follows the final result, and busy drops with it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_out) |=> (!rsp_valid && !busy))
      else $error("activity after final result");

   // busy only falls right after the final result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid && rsp_data.last_out))
      else $error("busy fell without a final result");

endmodule

bind merge_sort_engine_unit mse_checker u_checker (.*);
`default_nettype wire

FILE: tb/merge_sort_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine_unit_tb
// Self-checking bench for the block sorter: blocks of signed elements go in,
// each result is compared with a bottom-up merge sort kept in the bench.
// Directed blocks cover extremes, duplicates and ordering; random blocks of
// mixed sizes, full and overflowing ones among them, run at several idle rates.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit_tb;

   typedef enum int {
      MIX_WIDE,
      MIX_NARROW,
      MIX_EDGES
   } value_mix_type;

   typedef struct {
      mse_pkg::req_type payload;
      int               gap_pct;
   } pending_item_type;

   localparam logic signed [mse_pkg::DATA_WIDTH-1:0] VAL_MIN =
      {1'b1, {(mse_pkg::DATA_WIDTH-1){1'b0}}};
   localparam logic signed [mse_pkg::DATA_WIDTH-1:0] VAL_MAX =
      {1'b0, {(mse_pkg::DATA_WIDTH-1){1'b1}}};
   localparam int PHASE_ITEMS = 160;
   localparam int DRAIN_CYCLES = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   mse_pkg::req_type req_data = '0;
   logic             rsp_valid;
   mse_pkg::rsp_type rsp_data;

   pending_item_type pending_items[$];
   mse_pkg::rsp_type sorted_expect[$];

   // bench copy of the element store
   logic signed [mse_pkg::DATA_WIDTH-1:0] block_store[mse_pkg::MAX_ITEMS];
   logic signed [mse_pkg::DATA_WIDTH-1:0] merge_copy[mse_pkg::MAX_ITEMS];
   int fill_count = 0;
   bit dropped_seen = 1'b0;

   int error_count = 0;
   int items_taken = 0;
   int blocks_done = 0;
   int overflow_blocks = 0;
   int results_seen = 0;

   merge_sort_engine_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bottom-up merge, right run first on equal heads
   function automatic void sort_stored(input int n);
      int w;
      int lo;
      int mid;
      int hi;
      int a;
      int b;
      int k;
      for (w = 1; w < n; w = w * 2) begin
         for (lo = 0; lo < n; lo = lo + 2 * w) begin
            mid = (lo + w < n) ? lo + w : n;
            hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
            if (mid < hi) begin
               for (k = lo; k < hi; k++) merge_copy[k] = block_store[k];
               a = lo;
               b = mid;
               for (k = lo; k < hi; k++) begin
                  if (a < mid && b < hi) begin
                     if (merge_copy[a] < merge_copy[b]) begin
                        block_store[k] = merge_copy[a];
                        a++;
                     end else begin
                        block_store[k] = merge_copy[b];
                        b++;
                     end
                  end else if (a < mid) begin
                     block_store[k] = merge_copy[a];
                     a++;
                  end else begin
                     block_store[k] = merge_copy[b];
                     b++;
                  end
               end
            end
         end
      end
   endfunction

   function automatic void absorb_element(input mse_pkg::req_type item);
      mse_pkg::rsp_type r;
      int k;
      if (fill_count < mse_pkg::MAX_ITEMS) begin
         block_store[fill_count] = item.value;
         fill_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (item.last_in) begin
         sort_stored(fill_count);
         for (k = 0; k < fill_count; k++) begin
            r.sorted_value = block_store[k];
            r.last_out     = (k == fill_count - 1);
            r.overflowed   = dropped_seen;
            sorted_expect.push_back(r);
         end
         blocks_done++;
         if (dropped_seen) overflow_blocks++;
         fill_count   = 0;
         dropped_seen = 1'b0;
      end
   endfunction

   function automatic logic signed [mse_pkg::DATA_WIDTH-1:0] pick_value(
      input value_mix_type mix);
      logic signed [mse_pkg::DATA_WIDTH-1:0] v;
      case (mix)
         MIX_NARROW: begin
            v = int'($urandom_range(6)) - 3;
         end
         MIX_EDGES: begin
            case ($urandom_range(5))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               2: v = VAL_MIN + 1;
               3: v = VAL_MAX - 1;
               4: v = '0;
               default: v = '1;
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   function automatic void queue_element(input logic signed [mse_pkg::DATA_WIDTH-1:0] v,
                                         input logic last, input int gap_pct);
      pending_item_type p;
      p.payload.value   = v;
      p.payload.last_in = last;
      p.gap_pct         = gap_pct;
      pending_items.push_back(p);
   endfunction

   // returns the number of elements that the block will keep
   function automatic int queue_random_block(input int gap_pct);
      int n;
      int roll;
      int k;
      value_mix_type mix;
      roll = $urandom_range(99);
      if (roll < 60) n = $urandom_range(8, 1);
      else if (roll < 88) n = $urandom_range(mse_pkg::MAX_ITEMS - 1, 9);
      else if (roll < 94) n = mse_pkg::MAX_ITEMS;
      else n = $urandom_range(mse_pkg::MAX_ITEMS + 8, mse_pkg::MAX_ITEMS + 1);
      roll = $urandom_range(99);
      mix = (roll < 60) ? MIX_WIDE : (roll < 85) ? MIX_NARROW : MIX_EDGES;
      for (k = 0; k < n; k++) begin
         // a block may mix styles now and then
         if ($urandom_range(9) == 0) queue_element(pick_value(MIX_EDGES), k == n - 1, gap_pct);
         else queue_element(pick_value(mix), k == n - 1, gap_pct);
      end
      return (n > mse_pkg::MAX_ITEMS) ? mse_pkg::MAX_ITEMS : n;
   endfunction

   // driver: one item offered per cycle, taken only while busy is low, gaps drawn from the item's own rate
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            absorb_element(req_data);
            items_taken++;
            void'(pending_items.pop_front());
         end
         if (pending_items.size() > 0 && $urandom_range(99) >= pending_items[0].gap_pct) begin
            start    <= 1'b1;
            req_data <= pending_items[0].payload;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (sorted_expect.size() == 0) begin
            $error("unexpected result: sorted_value %0d", rsp_data.sorted_value);
            error_count++;
         end else begin
            if (rsp_data.sorted_value !== sorted_expect[0].sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      sorted_expect[0].sorted_value, rsp_data.sorted_value);
               error_count++;
            end
            if (rsp_data.last_out !== sorted_expect[0].last_out) begin
               $error("last_out: expected %0b, got %0b",
                      sorted_expect[0].last_out, rsp_data.last_out);
               error_count++;
            end
            if (rsp_data.overflowed !== sorted_expect[0].overflowed) begin
               $error("overflowed: expected %0b, got %0b",
                      sorted_expect[0].overflowed, rsp_data.overflowed);
               error_count++;
            end
            void'(sorted_expect.pop_front());
         end
      end
   end

   initial begin
      int gap_by_phase[3];
      int ph;
      int kept;
      gap_by_phase = '{0, 75, 20};

      // directed blocks
      queue_element(VAL_MIN, 1'b1, 0);
      queue_element(VAL_MAX, 1'b1, 0);
      queue_element(VAL_MAX, 1'b0, 0);
      queue_element(VAL_MIN, 1'b0, 0);
      queue_element('0, 1'b0, 0);
      queue_element('1, 1'b1, 0);
      queue_element(5, 1'b0, 0);
      queue_element(5, 1'b0, 0);
      queue_element(5, 1'b1, 0);
      queue_element(3, 1'b0, 0);
      queue_element(-3, 1'b0, 0);
      queue_element(3, 1'b0, 0);
      queue_element(-3, 1'b0, 0);
      queue_element(7, 1'b1, 0);
      queue_element(1, 1'b0, 0);
      queue_element(2, 1'b1, 0);
      queue_element(2, 1'b0, 0);
      queue_element(1, 1'b1, 0);

      // random blocks, one idle rate per phase
      for (ph = 0; ph < 3; ph++) begin
         kept = 0;
         while (kept < PHASE_ITEMS) kept += queue_random_block(gap_by_phase[ph]);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0) @(posedge clock);
      while (sorted_expect.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items in %0d blocks, %0d of them overflowing", items_taken,
               blocks_done, overflow_blocks);
      $display("checked %0d sorted results at idle rates of 0, 75 and 20 percent",
               results_seen);
      if (error_count == 0 && sorted_expect.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_ctrl.sv
rtl/mse_datapath.sv
rtl/merge_sort_engine_unit.sv
rtl/mse_checker.sv
tb/merge_sort_engine_unit_tb.sv
